// ===== rtl/gpio_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO port register package
// Shared constants, register index codes, transaction types and a helper for
// the GPIO port register block.
// ----------------------------------------------------------------------------
package gpio_pkg;

  localparam int NUM_PINS      = 54;
  localparam int FSEL_WORDS    = 6;
  localparam int PINS_PER_WORD = 10;
  localparam int SEL_BITS      = 3;
  localparam int WORD_W        = PINS_PER_WORD * SEL_BITS;
  localparam int WORD_IDX_W    = $clog2(FSEL_WORDS);
  localparam int HALF          = 32;
  localparam int HIGH_W        = 22;
  localparam int PULL_W        = 2;

  localparam logic [SEL_BITS-1:0] SEL_OUTPUT = 3'd1;
  localparam logic [SEL_BITS-1:0] SEL_MASK   = 3'd7;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [3:0] IDX_FSEL_0    = 4'd0;
  localparam logic [3:0] IDX_FSEL_1    = 4'd1;
  localparam logic [3:0] IDX_FSEL_2    = 4'd2;
  localparam logic [3:0] IDX_FSEL_3    = 4'd3;
  localparam logic [3:0] IDX_FSEL_4    = 4'd4;
  localparam logic [3:0] IDX_FSEL_5    = 4'd5;
  localparam logic [3:0] IDX_SET_LO    = 4'd6;
  localparam logic [3:0] IDX_SET_HI    = 4'd7;
  localparam logic [3:0] IDX_CLR_LO    = 4'd8;
  localparam logic [3:0] IDX_CLR_HI    = 4'd9;
  localparam logic [3:0] IDX_LEV_LO    = 4'd10;
  localparam logic [3:0] IDX_LEV_HI    = 4'd11;
  localparam logic [3:0] IDX_PULL_CODE = 4'd12;
  localparam logic [3:0] IDX_PCLK_LO   = 4'd13;
  localparam logic [3:0] IDX_PCLK_HI   = 4'd14;

  typedef struct packed {
    logic              action;
    logic [3:0]        reg_index;
    logic [31:0]       write_data;
    logic [31:0]       level_low;
    logic [HIGH_W-1:0] level_high;
  } in_t;

  typedef struct packed {
    logic [31:0]         read_data;
    logic [31:0]         drive_low;
    logic [HIGH_W-1:0]   drive_high;
    logic [31:0]         enable_low;
    logic [HIGH_W-1:0]   enable_high;
    logic [63:0]         pull_low;
    logic [2*HIGH_W-1:0] pull_high;
    logic                bad_register;
  } out_t;

  typedef struct packed {
    logic                  fsel_wr;
    logic                  fsel_rd;
    logic                  set_wr;
    logic                  clr_wr;
    logic                  lev_rd;
    logic                  pcode_wr;
    logic                  pcode_rd;
    logic                  pclk_wr;
    logic                  bank;
    logic [WORD_IDX_W-1:0] word;
    logic                  bad;
  } ctrl_t;

  function automatic logic [WORD_W-1:0] fsel_mask(int w);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int k = 0; k < PINS_PER_WORD; k++) begin
      if (w * PINS_PER_WORD + k < NUM_PINS) begin
        m[SEL_BITS*k +: SEL_BITS] = SEL_MASK;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/gpio_port_register_block.sv =====
// ----------------------------------------------------------------------------
// GPIO port register block
// Bus-access register port for a 54-pin GPIO: function select, set, clear,
// level, pull code and pull clock registers.
// ----------------------------------------------------------------------------
// Each input transaction is one register access: a read or a write to a
// register index, together with the sampled pin levels. Each access yields
// exactly one result transaction carrying the read data (zero for writes),
// the output latch, the output enables and the pull latch codes as they
// stand after the access, and a flag for an unknown register index.
// The input is captured in an input register; the decode and the state
// update happen between that register and the result register, which
// presents the result once the access has passed through both. One access
// is accepted in every cycle as long as results are taken.
// A synchronous active-low reset clears all pins to inputs, the output latch,
// the pull code and every pin pull latch, and empties both registers.
// When the receiver stalls, the result register holds its transaction and the
// input register takes one more access; in_ready then drops until the result
// is taken.
// ----------------------------------------------------------------------------
module gpio_port_register_block (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gpio_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gpio_pkg::out_t  out_data
);

  gpio_pkg::in_t   in_r;
  logic            in_valid_r, in_valid_nxt;
  gpio_pkg::out_t  out_r;
  logic            out_valid_r, out_valid_nxt;
  gpio_pkg::ctrl_t ctrl;
  gpio_pkg::out_t  res;
  logic            adv;
  logic            in_acc;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  gpio_dec u_dec (
    .action    (in_r.action),
    .reg_index (in_r.reg_index),
    .ctrl      (ctrl)
  );

  gpio_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctrl       (ctrl),
    .write_data (in_r.write_data),
    .level_low  (in_r.level_low),
    .level_high (in_r.level_high),
    .res        (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad_register) |-> (out_r.read_data == '0))
    else $error("Unknown register index returned nonzero read data.");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (in_r.action == gpio_pkg::ACT_WRITE)) |=> (out_r.read_data == '0))
    else $error("Write transaction returned nonzero read data.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("Input not ready while the result register is empty.");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("Advanced transaction did not reach the result register.");

endmodule

// ===== rtl/gpio_dec.sv =====
// ----------------------------------------------------------------------------
// GPIO register index decoder
// Turns the access kind and register index of a transaction into control flags.
// ----------------------------------------------------------------------------
module gpio_dec (
  input  logic              action,
  input  logic [3:0]        reg_index,
  output gpio_pkg::ctrl_t   ctrl
);

  logic wr;
  logic rd;

  assign wr = (action == gpio_pkg::ACT_WRITE);
  assign rd = (action == gpio_pkg::ACT_READ);

  always_comb begin
    ctrl      = '0;
    ctrl.word = reg_index[gpio_pkg::WORD_IDX_W-1:0];
    unique case (reg_index) inside
      gpio_pkg::IDX_FSEL_0, gpio_pkg::IDX_FSEL_1, gpio_pkg::IDX_FSEL_2,
      gpio_pkg::IDX_FSEL_3, gpio_pkg::IDX_FSEL_4, gpio_pkg::IDX_FSEL_5: begin
        ctrl.fsel_wr = wr;
        ctrl.fsel_rd = rd;
      end
      gpio_pkg::IDX_SET_LO, gpio_pkg::IDX_SET_HI: begin
        ctrl.set_wr = wr;
        ctrl.bank   = (reg_index == gpio_pkg::IDX_SET_HI);
      end
      gpio_pkg::IDX_CLR_LO, gpio_pkg::IDX_CLR_HI: begin
        ctrl.clr_wr = wr;
        ctrl.bank   = (reg_index == gpio_pkg::IDX_CLR_HI);
      end
      gpio_pkg::IDX_LEV_LO, gpio_pkg::IDX_LEV_HI: begin
        ctrl.lev_rd = rd;
        ctrl.bank   = (reg_index == gpio_pkg::IDX_LEV_HI);
      end
      gpio_pkg::IDX_PULL_CODE: begin
        ctrl.pcode_wr = wr;
        ctrl.pcode_rd = rd;
      end
      gpio_pkg::IDX_PCLK_LO, gpio_pkg::IDX_PCLK_HI: begin
        ctrl.pclk_wr = wr;
        ctrl.bank    = (reg_index == gpio_pkg::IDX_PCLK_HI);
      end
      default: begin
        ctrl.bad = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/gpio_core.sv =====
// ----------------------------------------------------------------------------
// GPIO port state and result logic
// Holds the select words, output latch, pull code and pin pull latches, applies
// one transaction when it advances and forms the result after the access.
// ----------------------------------------------------------------------------
module gpio_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  gpio_pkg::ctrl_t              ctrl,
  input  logic [31:0]                  write_data,
  input  logic [31:0]                  level_low,
  input  logic [gpio_pkg::HIGH_W-1:0]  level_high,
  output gpio_pkg::out_t               res
);

  localparam int NP = gpio_pkg::NUM_PINS;
  localparam int WW = gpio_pkg::WORD_W;
  localparam int FW = gpio_pkg::FSEL_WORDS;

  logic [FW-1:0][WW-1:0]                 sel_r, sel_nxt;
  logic [NP-1:0]                         latch_r, latch_nxt;
  logic [gpio_pkg::PULL_W-1:0]           pcode_r, pcode_nxt;
  logic [NP-1:0][gpio_pkg::PULL_W-1:0]   pull_r, pull_nxt;
  logic [FW-1:0][WW-1:0]                 fmask;
  logic [63:0]                           data64;
  logic [NP-1:0]                         bits;
  logic [63:0]                           lev64;
  logic [63:0]                           lev_m;
  logic [63:0]                           latch64;
  logic [63:0]                           en64;
  logic [127:0]                          pull128;
  logic [31:0]                           rd_data;

  genvar gw, gp;
  generate
    for (gw = 0; gw < FW; gw++) begin : g_mask
      assign fmask[gw] = gpio_pkg::fsel_mask(gw);
    end
  endgenerate

  assign data64 = ctrl.bank ? {write_data, 32'b0} : {32'b0, write_data};
  assign bits   = data64[NP-1:0];
  assign lev64  = {{(64 - gpio_pkg::HALF - gpio_pkg::HIGH_W){1'b0}}, level_high, level_low};

  always_comb begin
    lev_m = '0;
    lev_m[NP-1:0] = lev64[NP-1:0];
  end

  always_comb begin
    sel_nxt   = sel_r;
    latch_nxt = latch_r;
    pcode_nxt = pcode_r;
    pull_nxt  = pull_r;
    if (adv) begin
      if (ctrl.fsel_wr) begin
        sel_nxt[ctrl.word] = write_data[WW-1:0] & fmask[ctrl.word];
      end
      if (ctrl.set_wr) begin
        latch_nxt = latch_r | bits;
      end
      if (ctrl.clr_wr) begin
        latch_nxt = latch_r & ~bits;
      end
      if (ctrl.pcode_wr) begin
        pcode_nxt = write_data[gpio_pkg::PULL_W-1:0];
      end
      if (ctrl.pclk_wr) begin
        for (int p = 0; p < NP; p++) begin
          if (bits[p]) begin
            pull_nxt[p] = pcode_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      latch_r <= '0;
      pcode_r <= '0;
      pull_r  <= '0;
    end else begin
      sel_r   <= sel_nxt;
      latch_r <= latch_nxt;
      pcode_r <= pcode_nxt;
      pull_r  <= pull_nxt;
    end
  end

  always_comb begin
    rd_data = '0;
    if (ctrl.fsel_rd) begin
      rd_data = {{(32 - WW){1'b0}}, sel_r[ctrl.word]};
    end else if (ctrl.lev_rd) begin
      rd_data = ctrl.bank ? lev_m[63:32] : lev_m[31:0];
    end else if (ctrl.pcode_rd) begin
      rd_data = {{(32 - gpio_pkg::PULL_W){1'b0}}, pcode_r};
    end
  end

  generate
    for (gp = 0; gp < 64; gp++) begin : g_en
      if ((gp < NP) && (gp / gpio_pkg::PINS_PER_WORD < FW)) begin : g_pin
        localparam int W = gp / gpio_pkg::PINS_PER_WORD;
        localparam int K = gp % gpio_pkg::PINS_PER_WORD;
        assign en64[gp] =
          (sel_nxt[W][gpio_pkg::SEL_BITS*K +: gpio_pkg::SEL_BITS] == gpio_pkg::SEL_OUTPUT);
      end else begin : g_none
        assign en64[gp] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    latch64 = '0;
    latch64[NP-1:0] = latch_nxt;
    pull128 = '0;
    pull128[2*NP-1:0] = pull_nxt;
  end

  always_comb begin
    res.read_data    = rd_data;
    res.drive_low    = latch64[31:0];
    res.drive_high   = latch64[gpio_pkg::HALF +: gpio_pkg::HIGH_W];
    res.enable_low   = en64[31:0];
    res.enable_high  = en64[gpio_pkg::HALF +: gpio_pkg::HIGH_W];
    res.pull_low     = pull128[63:0];
    res.pull_high    = pull128[64 +: 2*gpio_pkg::HIGH_W];
    res.bad_register = ctrl.bad;
  end

endmodule
